// ===== src/ccs_pkg.sv =====
// Shared types and constants for the C comment stripper.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ccs_pkg;

   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;

   // Scanner mode. Codes 5 to 7 never arise and are treated as normal text.
   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_SLASH  = 3'd1,
      MODE_LINE   = 3'd2,
      MODE_BLOCK  = 3'd3,
      MODE_STAR   = 3'd4
   } scan_mode_type;

   // One result transaction without its last flag.
   typedef struct packed {
      logic [7:0] out_char;
      logic       line_done;
   } result_type;

   // All results caused by one input transaction: one, or two when pair is set.
   typedef struct packed {
      logic       pair;
      result_type first;
      result_type second;
   } job_type;

endpackage

// ===== src/ccs_stream_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on nothing.
`timescale 1ns / 1ps

interface ccs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_line;

   modport source (output valid, char_code, end_of_line, input ready);
   modport sink   (input valid, char_code, end_of_line, output ready);
endinterface

interface ccs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       line_done;
   logic       last;

   modport source (output valid, out_char, line_done, last, input ready);
   modport sink   (input valid, out_char, line_done, last, output ready);
endinterface

// ===== src/ccs_front.sv =====
// Front end: scans each accepted character; each that gives output becomes a job.
// Depends on ccs_pkg.
`timescale 1ns / 1ps

module ccs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [7:0]        in_char,
   input  logic              in_eol,
   output logic              in_ready,
   output logic              job_valid,
   input  logic              job_ready,
   output ccs_pkg::job_type  job
);

   ccs_pkg::scan_mode_type mode_ff, mode_in;
   logic                   text_ff, text_in;
   logic                   accept;
   logic                   emit;

   assign in_ready  = job_ready;
   assign accept    = in_valid && job_ready;
   assign job_valid = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ccs_pkg::MODE_NORMAL;
         text_ff <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         text_ff <= text_in;
      end
   end

   // Next mode.
   always_comb begin
      mode_in = ccs_pkg::MODE_NORMAL;
      if (in_eol) begin
         unique case (mode_ff) inside
            ccs_pkg::MODE_BLOCK,
            ccs_pkg::MODE_STAR:  mode_in = ccs_pkg::MODE_BLOCK;
            default:             mode_in = ccs_pkg::MODE_NORMAL;
         endcase
      end else begin
         unique case (mode_ff)
            ccs_pkg::MODE_SLASH: begin
               if (in_char == ccs_pkg::CHAR_SLASH)     mode_in = ccs_pkg::MODE_LINE;
               else if (in_char == ccs_pkg::CHAR_STAR) mode_in = ccs_pkg::MODE_BLOCK;
               else                                    mode_in = ccs_pkg::MODE_NORMAL;
            end
            ccs_pkg::MODE_LINE:  mode_in = ccs_pkg::MODE_LINE;
            ccs_pkg::MODE_BLOCK: begin
               mode_in = (in_char == ccs_pkg::CHAR_STAR) ? ccs_pkg::MODE_STAR
                                                         : ccs_pkg::MODE_BLOCK;
            end
            ccs_pkg::MODE_STAR: begin
               if (in_char == ccs_pkg::CHAR_SLASH)     mode_in = ccs_pkg::MODE_NORMAL;
               else if (in_char == ccs_pkg::CHAR_STAR) mode_in = ccs_pkg::MODE_STAR;
               else                                    mode_in = ccs_pkg::MODE_BLOCK;
            end
            default: begin
               mode_in = (in_char == ccs_pkg::CHAR_SLASH) ? ccs_pkg::MODE_SLASH
                                                          : ccs_pkg::MODE_NORMAL;
            end
         endcase
      end
   end

   // Job contents and line-has-text update.
   always_comb begin
      emit                = 1'b0;
      text_in             = text_ff;
      job.pair            = 1'b0;
      job.first.out_char  = 8'd0;
      job.first.line_done = 1'b0;
      job.second          = '0;
      if (in_eol) begin
         unique case (mode_ff) inside
            ccs_pkg::MODE_SLASH: begin
               emit                 = 1'b1;
               job.pair             = 1'b1;
               job.first.out_char   = ccs_pkg::CHAR_SLASH;
               job.second.line_done = 1'b1;
               text_in              = 1'b0;
            end
            ccs_pkg::MODE_BLOCK,
            ccs_pkg::MODE_STAR: begin
               emit = 1'b0;
            end
            default: begin
               emit                = text_ff;
               job.first.line_done = 1'b1;
               text_in             = 1'b0;
            end
         endcase
      end else begin
         unique case (mode_ff) inside
            ccs_pkg::MODE_SLASH: begin
               if (in_char != ccs_pkg::CHAR_SLASH && in_char != ccs_pkg::CHAR_STAR) begin
                  emit                = 1'b1;
                  job.pair            = 1'b1;
                  job.first.out_char  = ccs_pkg::CHAR_SLASH;
                  job.second.out_char = in_char;
                  text_in             = 1'b1;
               end
            end
            ccs_pkg::MODE_LINE,
            ccs_pkg::MODE_BLOCK,
            ccs_pkg::MODE_STAR: begin
               emit = 1'b0;
            end
            default: begin
               if (in_char != ccs_pkg::CHAR_SLASH) begin
                  emit               = 1'b1;
                  job.first.out_char = in_char;
                  text_in            = 1'b1;
               end
            end
         endcase
      end
   end

endmodule

// ===== src/ccs_job_queue.sv =====
// Two-entry queue of jobs between the scanner and the output sequencer.
// Depends on ccs_pkg.
`timescale 1ns / 1ps

module ccs_job_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  ccs_pkg::job_type  push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output ccs_pkg::job_type  pop_job
);

   ccs_pkg::job_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== src/ccs_back.sv =====
// Back end: plays each job out as one or two response transactions.
// Depends on ccs_pkg.
`timescale 1ns / 1ps

module ccs_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_pop,
   input  ccs_pkg::job_type  job,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [7:0]        out_char,
   output logic              out_line_done,
   output logic              out_last
);

   logic                 valid_ff;
   logic                 phase_ff, phase_in;
   ccs_pkg::result_type  result_ff, result_in;
   logic                 last_ff, last_in;
   logic                 load;

   assign load = job_valid && (!valid_ff || out_ready);

   always_comb begin
      result_in = phase_ff ? job.second : job.first;
      last_in   = !job.pair || phase_ff;
      job_pop   = load && last_in;
      phase_in  = phase_ff;
      if (load) begin
         phase_in = !last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (load) begin
            valid_ff <= 1'b1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
         last_ff   <= last_in;
      end
   end

   assign out_valid     = valid_ff;
   assign out_char      = result_ff.out_char;
   assign out_line_done = result_ff.line_done;
   assign out_last      = last_ff;

endmodule

// ===== src/c_comment_stripper.sv =====
// C comment stripper, top level.
// Depends on ccs_pkg, ccs_stream_if, ccs_front, ccs_job_queue and ccs_back.
//
// Usage:
// The request channel carries one source character per transaction, or an
// end-of-line marker when end_of_line is high (char_code is then ignored).
// The response channel carries the kept characters and a line_done marker
// for every output line that is not empty. The last flag is set on the
// final response caused by a request; requests that cause nothing (comment
// text, a slash that may open a comment, an empty line) give no response.
// An accepted request passes through the job queue and the output register
// before its first response appears. One request per cycle is sustained
// while each causes at most one response; a pending slash that is released
// gives two responses, which the single output port sends one at a time.
// The two-entry job queue between scanner and output register absorbs such
// bursts, so the request side stalls only when the queue fills.
// Synchronous reset returns the scanner to normal text with an empty line
// and empties the queue and the output register. When the receiver holds
// rsp ready low, the response stays stable and the queue fills, after which
// req ready drops until the receiver takes transactions again.
`timescale 1ns / 1ps

module c_comment_stripper (
   input  logic           clock,
   input  logic           reset,
   ccs_req_if.sink        req_stream,
   ccs_rsp_if.source      rsp_stream
);

   logic             front_valid;
   logic             front_ready;
   ccs_pkg::job_type front_job;
   logic             queue_valid;
   logic             queue_pop;
   ccs_pkg::job_type queue_job;

   // The scanner decides every transaction in the cycle it is accepted and
   // only forwards requests that produce output.
   ccs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_stream.valid),
      .in_char   (req_stream.char_code),
      .in_eol    (req_stream.end_of_line),
      .in_ready  (req_stream.ready),
      .job_valid (front_valid),
      .job_ready (front_ready),
      .job       (front_job)
   );

   ccs_job_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_job   (front_job),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_pop),
      .pop_job    (queue_job)
   );

   // The output sequencer splits a two-result job over two transactions.
   ccs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (queue_valid),
      .job_pop       (queue_pop),
      .job           (queue_job),
      .out_valid     (rsp_stream.valid),
      .out_ready     (rsp_stream.ready),
      .out_char      (rsp_stream.out_char),
      .out_line_done (rsp_stream.line_done),
      .out_last      (rsp_stream.last)
   );

endmodule
